// ----- src/swer_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swer_pkg: shared types and constants of the sliding-window event rate meter
// Field widths, opcodes, register indexes, controller states and the command
// and status words between controller and datapath.
// ----------------------------------------------------------------------------
package swer_pkg;

  localparam int TIME_BITS     = 32;
  localparam int ID_BITS       = 4;
  localparam int NUM_IDS       = 16;
  localparam int OP_BITS       = 2;
  localparam int WC_OUT_BITS   = 9;
  localparam int TOTAL_BITS    = 32;
  localparam int RATE_BITS     = 32;
  localparam int SCALE_BITS    = 24;
  localparam int WLEN_BITS     = 31;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 31;

  localparam logic [WLEN_BITS-1:0]  WLEN_RESET  = 31'd60000;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'd65536;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_SCALE    = 1'b1;

  typedef enum logic [OP_BITS-1:0] {
    OP_RECORD    = 2'd0,
    OP_QUERY_ONE = 2'd1,
    OP_QUERY_ALL = 2'd2,
    OP_NONE      = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_CHECK,
    ST_EXP_READ,
    ST_ACT,
    ST_EMIT,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic pop;
    logic act;
    logic emit_one;
    logic scan_step;
  } swer_cmd_t;

  typedef struct packed {
    logic    expire_due;
    logic    out_free;
    logic    scan_last;
    opcode_t op;
  } swer_stat_t;

endpackage

// ----- src/swer_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swer_if: input and result channels of the event rate meter
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface swer_in_if;
  import swer_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_BITS-1:0]   opcode;
  logic [ID_BITS-1:0]   event_id;
  logic [TIME_BITS-1:0] now_time;

  modport source (output valid, opcode, event_id, now_time, input ready);
  modport sink   (input valid, opcode, event_id, now_time, output ready);
endinterface

interface swer_out_if;
  import swer_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ID_BITS-1:0]     out_id;
  logic [WC_OUT_BITS-1:0] window_count;
  logic [TOTAL_BITS-1:0]  total_count;
  logic [RATE_BITS-1:0]   rate_value;
  logic                   has_entry;
  logic                   status;
  logic                   last;

  modport source (output valid, out_id, window_count, total_count, rate_value,
                  has_entry, status, last, input ready);
  modport sink   (input valid, out_id, window_count, total_count, rate_value,
                  has_entry, status, last, output ready);
endinterface

// ----- src/swer_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swer_ctrl: sequencer of the event rate meter
// Walks each word through expiry, the opcode's action and, for record and query opcodes, result delivery.
// ----------------------------------------------------------------------------
module swer_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  swer_pkg::swer_stat_t stat,
  output swer_pkg::swer_cmd_t  cmd
);
  import swer_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXP_CHECK;
      end
      ST_EXP_CHECK: begin
        state_next = stat.expire_due ? ST_EXP_READ : ST_ACT;
      end
      ST_EXP_READ: begin
        state_next = ST_EXP_CHECK;
      end
      ST_ACT: begin
        case (stat.op)
          OP_RECORD:    state_next = ST_EMIT;
          OP_QUERY_ONE: state_next = ST_EMIT;
          OP_QUERY_ALL: state_next = ST_SCAN;
          default:      state_next = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (stat.out_free && stat.scan_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_EXP_CHECK: cmd.pop       = stat.expire_due;
      ST_ACT:       cmd.act       = 1'b1;
      ST_EMIT:      cmd.emit_one  = stat.out_free;
      ST_SCAN:      cmd.scan_step = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ----- src/swer_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swer_dp: datapath of the event rate meter
// Event FIFO memory and pointers, per-id counters, id scan, rate multiply,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module swer_dp #(
  parameter int EVENT_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  swer_pkg::swer_cmd_t                 cmd,
  output swer_pkg::swer_stat_t                stat,
  input  logic [swer_pkg::OP_BITS-1:0]        in_opcode,
  input  logic [swer_pkg::ID_BITS-1:0]        in_event_id,
  input  logic [swer_pkg::TIME_BITS-1:0]      in_now_time,
  input  logic                                cfg_we,
  input  logic [swer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [swer_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swer_pkg::ID_BITS-1:0]        out_id,
  output logic [swer_pkg::WC_OUT_BITS-1:0]    out_window_count,
  output logic [swer_pkg::TOTAL_BITS-1:0]     out_total_count,
  output logic [swer_pkg::RATE_BITS-1:0]      out_rate_value,
  output logic                                out_has_entry,
  output logic                                out_status,
  output logic                                out_last
);
  import swer_pkg::*;

  localparam int PTR_BITS  = $clog2(EVENT_DEPTH);
  localparam int FILL_BITS = $clog2(EVENT_DEPTH + 1);
  localparam int WC_BITS   = FILL_BITS;
  localparam int PROD_BITS = WC_OUT_BITS + SCALE_BITS;

  localparam logic [PTR_BITS-1:0]  PTR_LAST = PTR_BITS'(EVENT_DEPTH - 1);
  localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(EVENT_DEPTH);

  // latched word
  opcode_t              op_q;
  logic [ID_BITS-1:0]   id_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 drop_q;

  // configuration
  logic [WLEN_BITS-1:0]  wlen;
  logic [SCALE_BITS-1:0] scale;

  // event FIFO
  logic [TIME_BITS-1:0] mem_time [EVENT_DEPTH];
  logic [ID_BITS-1:0]   mem_kind [EVENT_DEPTH];
  logic [TIME_BITS-1:0] rd_time;
  logic [ID_BITS-1:0]   rd_kind;
  logic [PTR_BITS-1:0]  head;
  logic [PTR_BITS-1:0]  tail;
  logic [FILL_BITS-1:0] fill;
  logic                 full;
  logic                 push_en;
  logic [TIME_BITS-1:0] passed;

  // per-id counters
  logic [WC_BITS-1:0]    wc [NUM_IDS];
  logic [TOTAL_BITS-1:0] lt [NUM_IDS];

  // id scan
  logic [ID_BITS-1:0] scan_idx;
  logic [NUM_IDS-1:0] masked;
  logic [NUM_IDS-1:0] rest;
  logic [ID_BITS-1:0] found_id;
  logic               found_any;
  logic               more;

  // result selection
  logic                          out_load;
  logic [ID_BITS-1:0]            sel_id;
  logic                          sel_has;
  logic [WC_BITS-1:0]            sel_wc;
  logic [WC_BITS+WC_OUT_BITS-1:0] sel_wc_wide;
  logic [WC_OUT_BITS-1:0]        sel_wc9;
  logic [TOTAL_BITS-1:0]         sel_lt;
  logic [PROD_BITS-1:0]          prod;
  logic                          out_free;

  assign full     = (fill == FILL_MAX);
  assign push_en  = cmd.act && (op_q == OP_RECORD) && !full;
  assign passed   = now_q - rd_time;
  assign out_free = !out_valid || out_ready;

  assign stat.expire_due = (fill != '0) && (passed > {1'b0, wlen});
  assign stat.out_free   = out_free;
  assign stat.scan_last  = !more;
  assign stat.op         = op_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= opcode_t'(in_opcode);
      id_q  <= in_event_id;
      now_q <= in_now_time;
    end
    if (cmd.act) begin
      drop_q <= (op_q == OP_RECORD) && full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen  <= WLEN_RESET;
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WINDOW_LENGTH) wlen  <= cfg_data[WLEN_BITS-1:0];
      if (cfg_index == CFG_RATE_SCALE)    scale <= cfg_data[SCALE_BITS-1:0];
    end
  end

  // read port follows the head every cycle
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_time[tail] <= now_q;
      mem_kind[tail] <= id_q;
    end
    rd_time <= mem_time[head];
    rd_kind <= mem_kind[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else if (cmd.pop) begin
      head <= (head == PTR_LAST) ? '0 : head + 1'b1;
      fill <= fill - 1'b1;
    end else if (push_en) begin
      tail <= (tail == PTR_LAST) ? '0 : tail + 1'b1;
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_IDS; i++) begin
        wc[i] <= '0;
        lt[i] <= '0;
      end
    end else if (cmd.pop) begin
      // hold at zero rather than wrap
      if (wc[rd_kind] != '0) wc[rd_kind] <= wc[rd_kind] - 1'b1;
    end else if (push_en) begin
      wc[id_q] <= wc[id_q] + 1'b1;
      if (lt[id_q] != '1) lt[id_q] <= lt[id_q] + 1'b1;
    end
  end

  always_comb begin
    masked   = '0;
    found_id = '0;
    for (int i = 0; i < NUM_IDS; i++) begin
      masked[i] = (wc[i] != '0) && (ID_BITS'(i) >= scan_idx);
    end
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (masked[i]) found_id = ID_BITS'(i);
    end
  end

  assign found_any = |masked;
  assign rest      = masked & ~(NUM_IDS'(1) << found_id);
  assign more      = |rest;

  always_ff @(posedge clk) begin
    if (cmd.act) begin
      scan_idx <= '0;
    end else if (cmd.scan_step && more) begin
      scan_idx <= found_id + 1'b1;
    end
  end

  assign out_load    = cmd.emit_one || cmd.scan_step;
  assign sel_id      = cmd.emit_one ? id_q : found_id;
  assign sel_has     = cmd.emit_one || found_any;
  assign sel_wc      = sel_has ? wc[sel_id] : '0;
  assign sel_lt      = sel_has ? lt[sel_id] : '0;
  assign sel_wc_wide = {{WC_OUT_BITS{1'b0}}, sel_wc};
  assign sel_wc9     = sel_wc_wide[WC_OUT_BITS-1:0];
  assign prod        = {{SCALE_BITS{1'b0}}, sel_wc9} * {{WC_OUT_BITS{1'b0}}, scale};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id           <= sel_has ? sel_id : '0;
      out_window_count <= sel_wc9;
      out_total_count  <= sel_lt;
      out_rate_value   <= prod[RATE_BITS-1:0];
      out_has_entry    <= sel_has;
      out_status       <= cmd.emit_one && drop_q;
      out_last         <= cmd.emit_one || !more;
    end
  end

endmodule

// ----- src/sliding_window_event_rate_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_event_rate_top: per-id sliding-window event rate meter
// Records timestamped events per id, expires those older than the window
// and reports window count, lifetime count and rate per id.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : one word per request: opcode, event_id, now_time.
//   out_ch : result words; last marks the final word of a request.
//   cfg_*  : write window_length (index 0) or rate_scale (index 1) while idle.
// Timing
//   One request at a time. A record or single query passes from acceptance
//   through a pop for each stored event that expires and the action to the
//   result register: each pop is a read of the event memory at the head and
//   a compare. A query over all ids loads its words one by one as the result
//   register frees. The next request is accepted the cycle after the last
//   result word is loaded, while that word may still wait in the register.
// Reset
//   Counters, FIFO pointers, config, state and out_valid return to defaults;
//   the event memory is not cleared, as only filled entries are ever read.
// Back-pressure
//   A stalled receiver holds the result word; the sequencer waits on it.
// ----------------------------------------------------------------------------
module sliding_window_event_rate_top #(
  parameter int EVENT_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  swer_in_if.sink                            in_ch,
  swer_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [swer_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [swer_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import swer_pkg::*;

  swer_cmd_t  cmd;
  swer_stat_t stat;

  swer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swer_dp #(
    .EVENT_DEPTH (EVENT_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_ch.opcode),
    .in_event_id      (in_ch.event_id),
    .in_now_time      (in_ch.now_time),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_id           (out_ch.out_id),
    .out_window_count (out_ch.window_count),
    .out_total_count  (out_ch.total_count),
    .out_rate_value   (out_ch.rate_value),
    .out_has_entry    (out_ch.has_entry),
    .out_status       (out_ch.status),
    .out_last         (out_ch.last)
  );

endmodule

// ----- src/swer_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swer_chk: port checker of the event rate meter
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module swer_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [swer_pkg::ID_BITS-1:0]     out_id,
  input logic [swer_pkg::WC_OUT_BITS-1:0] window_count,
  input logic [swer_pkg::TOTAL_BITS-1:0]  total_count,
  input logic [swer_pkg::RATE_BITS-1:0]   rate_value,
  input logic                             has_entry,
  input logic                             status,
  input logic                             last
);
  import swer_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_id)
      && $stable(window_count) && $stable(total_count) && $stable(rate_value)
      && $stable(has_entry) && $stable(status) && $stable(last))
    else $error("result word changed while stalled");

  // one request at a time: ready drops after each acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // the empty query-all word is the only and final word, all zero
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_entry |-> last && !status && out_id == '0
      && window_count == '0 && total_count == '0 && rate_value == '0)
    else $error("malformed empty result word");

  // a dropped record reports on an id and closes its request
  a_drop_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> has_entry && last)
    else $error("drop flag on a word that is not a record result");

endmodule

bind sliding_window_event_rate_top swer_chk u_swer_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_id       (out_ch.out_id),
  .window_count (out_ch.window_count),
  .total_count  (out_ch.total_count),
  .rate_value   (out_ch.rate_value),
  .has_entry    (out_ch.has_entry),
  .status       (out_ch.status),
  .last         (out_ch.last)
);
